// ===== design/a64_pkg.sv =====
package a64_pkg;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_EXEC = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [31:0] HALT_INSN = 32'h8a000000;
	localparam logic [4:0] ZERO_REG = 5'd31;
	localparam logic [3:0] FLAGS_RESET = 4'b0100;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PWR,
		ST_FETCH,
		ST_DECODE,
		ST_REGRD,
		ST_MUL,
		ST_EXEC,
		ST_LDRD,
		ST_LDWR,
		ST_STWR,
		ST_RDBK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        is_mul;
		logic [4:0]  x_idx;
		logic        rd_we;
		logic [4:0]  rd_idx;
		logic [63:0] rd_val;
		logic        fl_we;
		logic [3:0]  fl;
		logic [63:0] next_pc;
		logic        mem_en;
		logic        mem_ld;
		logic        mem_fault;
		logic        mem_8;
		logic [63:0] mem_ea;
		logic [4:0]  t_idx;
		logic [63:0] st_val;
		logic        wb_we;
		logic [4:0]  wb_idx;
		logic [63:0] wb_val;
	} exec_res_t;

endpackage

// ===== design/a64_ram.sv =====
module a64_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/a64_exec.sv =====
module a64_exec #(
	parameter int MEM_BYTES = 65536
) (
	input  logic [31:0]             insn,
	input  logic [63:0]             pc,
	input  logic [63:0]             opa,
	input  logic [63:0]             opb,
	input  logic [63:0]             opc,
	input  logic [63:0]             prod,
	input  logic [3:0]              flags,
	output a64_pkg::exec_res_t      res
);

	import a64_pkg::*;

	function automatic logic [63:0] shifted(input logic [63:0] v_in, input logic [1:0] sty,
			input logic [5:0] amt, input logic wide);
		logic [63:0] m;
		logic [63:0] v;
		logic [63:0] r;
		logic [6:0] s;
		logic msb;
		m = wide ? 64'hFFFFFFFFFFFFFFFF : 64'h00000000FFFFFFFF;
		v = v_in & m;
		s = wide ? {1'b0, amt} : {2'b0, amt[4:0]};
		msb = wide ? v[63] : v[31];
		r = v;
		if (s != 7'd0) begin
			case (sty)
				2'd0: r = (v << s) & m;
				2'd1: r = v >> s;
				2'd2: r = (v >> s) | (msb ? (m & ~(m >> s)) : 64'd0);
				default: r = ((v >> s) | (v << ((wide ? 7'd64 : 7'd32) - s))) & m;
			endcase
		end
		return r;
	endfunction

	function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
		logic r;
		case (cc[3:1])
			3'd0: r = f[2];
			3'd1: r = f[1];
			3'd2: r = f[3];
			3'd3: r = f[0];
			3'd4: r = f[1] && !f[2];
			3'd5: r = (f[3] == f[0]);
			3'd6: r = (f[3] == f[0]) && !f[2];
			default: r = 1'b1;
		endcase
		if (cc[0] && cc != 4'hF) begin
			r = !r;
		end
		return r;
	endfunction

	logic        wide;
	logic [63:0] m;
	logic        c_dpi, c_dpr, c_ls, c_br;
	logic        as_en, as_minus, as_setf;
	logic [63:0] as_a, as_b, as_b2, as_val;
	logic [64:0] as_sum;
	logic        as_c, as_v;
	logic [63:0] op2, lval, hole, wimm, mval;
	logic [1:0]  hw;
	logic [63:0] off9, ea, sz;

	assign wide = insn[31];
	assign m = wide ? 64'hFFFFFFFFFFFFFFFF : 64'h00000000FFFFFFFF;
	assign c_dpi = (insn[28:26] == 3'b100);
	assign c_dpr = !c_dpi && (insn[27:25] == 3'b101);
	assign c_ls = !c_dpi && !c_dpr && insn[27] && !insn[25];
	assign c_br = !c_dpi && !c_dpr && !c_ls && (insn[28:26] == 3'b101);
	assign hw = insn[22:21];
	assign wimm = {48'd0, insn[20:5]} << {hw, 4'b0};
	assign hole = 64'h000000000000FFFF << {hw, 4'b0};
	assign sz = insn[30] ? 64'd8 : 64'd4;
	assign off9 = {{55{insn[20]}}, insn[20:12]};

	always_comb begin
		op2 = shifted(opb, (insn[23:22] == 2'd3) ? 2'd2 : insn[23:22], insn[15:10], wide);
		as_a = opa & m;
		as_b = op2;
		as_en = 1'b0;
		if (c_dpi) begin
			as_b = insn[22] ? {40'd0, insn[21:10], 12'd0} : {52'd0, insn[21:10]};
			as_en = (insn[25:23] == 3'd2);
		end else if (c_dpr && !insn[28] && insn[24]) begin
			as_en = 1'b1;
		end
		as_minus = insn[30];
		as_setf = insn[29];
		as_b2 = (as_minus ? ~as_b : as_b) & m;
		as_sum = {1'b0, as_a} + {1'b0, as_b2} + {64'd0, as_minus};
		as_val = as_sum[63:0] & m;
		as_c = wide ? as_sum[64] : as_sum[32];
		as_v = wide ? ((as_a[63] ^ as_val[63]) & (as_b2[63] ^ as_val[63]))
			: ((as_a[31] ^ as_val[31]) & (as_b2[31] ^ as_val[31]));
	end

	always_comb begin
		lval = shifted(opb, insn[23:22], insn[15:10], wide);
		if (insn[21]) begin
			lval = ~lval & m;
		end
		case (insn[30:29])
			2'd1: lval = (opa & m) | lval;
			2'd2: lval = (opa & m) ^ lval;
			default: lval = (opa & m) & lval;
		endcase
		mval = (insn[15] ? (opc - prod) : (opc + prod)) & m;
	end

	always_comb begin
		ea = opa;
		if (insn[31]) begin
			if (insn[24]) begin
				ea = opa + (insn[30] ? {49'd0, insn[21:10], 3'd0} : {50'd0, insn[21:10], 2'd0});
			end else if (insn[21]) begin
				ea = opa + opb;
			end else if (insn[11]) begin
				ea = opa + off9;
			end
		end else begin
			ea = pc + {{43{insn[23]}}, insn[23:5], 2'b0};
		end
	end

	always_comb begin
		res = '0;
		res.is_mul = c_dpr && insn[28];
		res.x_idx = (c_dpr && insn[28]) ? insn[14:10] : insn[4:0];
		res.rd_idx = insn[4:0];
		res.next_pc = pc + 64'd4;
		res.fl = flags;
		res.t_idx = insn[4:0];
		res.wb_idx = insn[9:5];
		res.mem_8 = insn[30];
		res.mem_ea = ea;
		if (c_dpi) begin
			if (as_en) begin
				res.rd_we = 1'b1;
				res.rd_val = as_val;
				if (as_setf) begin
					res.fl_we = 1'b1;
					res.fl = {as_val[wide ? 63 : 31], as_val == 64'd0, as_c, as_v};
				end
			end else if (insn[25:23] == 3'd5) begin
				case (insn[30:29])
					2'd0: begin
						res.rd_we = 1'b1;
						res.rd_val = ~wimm & m;
					end
					2'd2: begin
						res.rd_we = 1'b1;
						res.rd_val = wimm & m;
					end
					2'd3: begin
						res.rd_we = 1'b1;
						res.rd_val = ((opc & ~hole) | wimm) & m;
					end
					default: res.rd_we = 1'b0;
				endcase
			end
		end else if (c_dpr) begin
			res.rd_we = 1'b1;
			if (as_en) begin
				res.rd_val = as_val;
				if (as_setf) begin
					res.fl_we = 1'b1;
					res.fl = {as_val[wide ? 63 : 31], as_val == 64'd0, as_c, as_v};
				end
			end else if (insn[28]) begin
				res.rd_val = mval;
			end else begin
				res.rd_val = lval;
				if (insn[30:29] == 2'd3) begin
					res.fl_we = 1'b1;
					res.fl = {lval[wide ? 63 : 31], lval == 64'd0, 2'b00};
				end
			end
		end else if (c_ls) begin
			res.mem_en = 1'b1;
			res.mem_ld = insn[31] ? insn[22] : 1'b1;
			res.wb_we = insn[31] && !insn[24] && !insn[21];
			res.wb_val = insn[11] ? ea : (opa + off9);
			res.mem_fault = (ea > (64'(MEM_BYTES) - sz));
			res.st_val = (res.wb_we && insn[9:5] == insn[4:0] && insn[9:5] != ZERO_REG)
				? res.wb_val : opc;
		end else if (c_br) begin
			if (insn[31:29] == 3'd0) begin
				res.next_pc = pc + {{36{insn[25]}}, insn[25:0], 2'b0};
			end else if (insn[31:29] == 3'd6) begin
				res.next_pc = opa;
			end else if (insn[31:29] == 3'd2 && cond_holds(insn[3:0], flags)) begin
				res.next_pc = pc + {{43{insn[23]}}, insn[23:5], 2'b0};
			end
		end
		if (res.rd_idx == ZERO_REG) begin
			res.rd_we = 1'b0;
		end
		if (res.wb_idx == ZERO_REG) begin
			res.wb_we = 1'b0;
		end
	end

endmodule

// ===== design/a64_subset_instruction_executor.sv =====
// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser func, tdata address, data, reg
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata reg, word, pc, nzcv, halt, fault
// cfg       in         cfg_valid / cfg_ready           cfg_data program_words
//
// from transfer to result the steps are paced by the byte-wide data memory
// (one byte per cycle) and the single-read register file.
// after reset the data memory is zeroed one byte a cycle; no s_axis item is taken, cfg still is.
// MEM_BYTES must be a power of two (the block does not check); addresses wrap by masking.
// a new item is taken while the previous result waits; the result step waits for the slot.
module a64_subset_instruction_executor #(
	parameter int MEM_BYTES = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [55:0]   s_axis_tdata,  // mem_address, mem_data, reg_index
	input  logic [1:0]    s_axis_tuser,  // func
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [167:0]  m_axis_tdata,  // reg_value, mem_word, pc_value, nzcv, halted, fault
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [14:0]   cfg_data
);

	import a64_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	state_t state_q, state_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [AW-1:0] clr_q;
	logic [14:0] pw_q;
	logic [1:0]  func_q;
	logic [AW-1:0] madr_q;
	logic [31:0] mdata_q;
	logic [4:0]  ri_q;
	logic [63:0] pc_q;
	logic [3:0]  fl_q;
	logic        halted_q, fault_q;
	logic [31:0] insn_q;
	logic [63:0] buf_q, opa_q, opb_q, opc_q, prod_q, regv_q, stv_q;
	logic [AW-1:0] ea_q;
	logic        len8_q;
	logic [4:0]  tix_q;
	logic [30:0] rvalid_q;
	logic        rvld_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr, rd_base;
	logic [7:0]    mem_wdata, mem_rdata;
	logic          rf_we;
	logic [4:0]    rf_waddr, rf_raddr;
	logic [63:0]   rf_wdata, rf_rdata, rf_rd;
	logic [3:0]    rd_len;
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   mul_p;
	logic          out_load;
	exec_res_t     xr;

	a64_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	a64_ram #(.WIDTH(64), .DEPTH(32)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	a64_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
		.insn(insn_q), .pc(pc_q), .opa(opa_q), .opb(opb_q), .opc(opc_q),
		.prod(prod_q), .flags(fl_q), .res(xr)
	);

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign rf_rd = rvld_q ? rf_rdata : 64'd0;
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	always_comb begin
		unique case (state_q)
			ST_FETCH: rd_base = pc_q[AW-1:0];
			ST_LDRD: rd_base = ea_q;
			default: rd_base = madr_q;
		endcase
		rd_len = (state_q == ST_LDRD && len8_q) ? 4'd8 : 4'd4;
		mem_raddr = rd_base + AW'(cnt_q[2:0]);
		case (cnt_q[1:0])
			2'd0: rf_raddr = insn_q[9:5];
			2'd1: rf_raddr = insn_q[20:16];
			default: rf_raddr = xr.x_idx;
		endcase
		if (state_q == ST_RDBK) begin
			rf_raddr = ri_q;
		end
		case (cnt_q[1:0])
			2'd0: begin
				mul_a = opa_q[31:0];
				mul_b = opb_q[31:0];
			end
			2'd1: begin
				mul_a = opa_q[31:0];
				mul_b = opb_q[63:32];
			end
			default: begin
				mul_a = opa_q[63:32];
				mul_b = opb_q[31:0];
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		mem_we = 1'b0;
		mem_waddr = madr_q + AW'(cnt_q[1:0]);
		mem_wdata = 8'(mdata_q >> {cnt_q[1:0], 3'b0});
		rf_we = 1'b0;
		rf_waddr = xr.rd_idx;
		rf_wdata = xr.rd_val;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'd0;
				if (clr_q == AW'(MEM_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cnt_d = 4'd0;
				if (s_axis_tvalid) begin
					unique case (s_axis_tuser)
						FUNC_WRITE: state_d = ST_PWR;
						FUNC_EXEC: begin
							if (halted_q || (pc_q[63:2] >= {47'd0, pw_q})) begin
								state_d = ST_RDBK;
							end else begin
								state_d = ST_FETCH;
							end
						end
						default: state_d = ST_RDBK;
					endcase
				end
			end
			ST_PWR: begin
				mem_we = 1'b1;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd3) begin
					state_d = ST_RDBK;
					cnt_d = 4'd0;
				end
			end
			ST_FETCH, ST_LDRD, ST_RDBK: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == rd_len) begin
					cnt_d = 4'd0;
					unique case (state_q)
						ST_FETCH: state_d = ST_DECODE;
						ST_LDRD: state_d = ST_LDWR;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_DECODE: begin
				state_d = (buf_q[63:32] == HALT_INSN) ? ST_RDBK : ST_REGRD;
			end
			ST_REGRD: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd3) begin
					cnt_d = 4'd0;
					state_d = xr.is_mul ? ST_MUL : ST_EXEC;
				end
			end
			ST_MUL: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd2) begin
					cnt_d = 4'd0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (xr.mem_en) begin
					rf_we = xr.wb_we;
					rf_waddr = xr.wb_idx;
					rf_wdata = xr.wb_val;
					if (xr.mem_fault) begin
						state_d = ST_RDBK;
					end else begin
						state_d = xr.mem_ld ? ST_LDRD : ST_STWR;
					end
				end else begin
					rf_we = xr.rd_we;
					state_d = ST_RDBK;
				end
			end
			ST_LDWR: begin
				rf_we = (tix_q != ZERO_REG);
				rf_waddr = tix_q;
				rf_wdata = len8_q ? buf_q : {32'd0, buf_q[63:32]};
				state_d = ST_RDBK;
			end
			ST_STWR: begin
				mem_we = 1'b1;
				mem_waddr = ea_q + AW'(cnt_q[2:0]);
				mem_wdata = 8'(stv_q >> {cnt_q[2:0], 3'b0});
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == (len8_q ? 4'd7 : 4'd3)) begin
					cnt_d = 4'd0;
					state_d = ST_RDBK;
				end
			end
			ST_DONE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= 4'd0;
			clr_q <= '0;
			pw_q <= 15'd0;
			pc_q <= 64'd0;
			fl_q <= FLAGS_RESET;
			halted_q <= 1'b0;
			fault_q <= 1'b0;
			rvalid_q <= '0;
			rvld_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
			func_q <= FUNC_WRITE;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_valid) begin
				pw_q <= cfg_data;
			end
			rvld_q <= (rf_raddr != ZERO_REG) && rvalid_q[rf_raddr];
			if (rf_we) begin
				rvalid_q[rf_waddr] <= 1'b1;
			end
			if (state_q == ST_IDLE && s_axis_tvalid) begin
				func_q <= s_axis_tuser;
				fault_q <= 1'b0;
				if (s_axis_tuser == FUNC_EXEC && !halted_q
						&& (pc_q[63:2] >= {47'd0, pw_q})) begin
					halted_q <= 1'b1;
				end
			end
			if (state_q == ST_DECODE && buf_q[63:32] == HALT_INSN) begin
				halted_q <= 1'b1;
			end
			if (state_q == ST_EXEC) begin
				pc_q <= xr.next_pc;
				if (xr.fl_we) begin
					fl_q <= xr.fl;
				end
				if (xr.mem_en && xr.mem_fault) begin
					fault_q <= 1'b1;
				end
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			madr_q <= AW'(s_axis_tdata[15:0]);
			mdata_q <= s_axis_tdata[47:16];
			ri_q <= s_axis_tdata[52:48];
		end
		if ((state_q == ST_FETCH || state_q == ST_LDRD || state_q == ST_RDBK)
				&& cnt_q != 4'd0) begin
			buf_q <= {mem_rdata, buf_q[63:8]};
		end
		if (state_q == ST_RDBK && cnt_q == 4'd1) begin
			regv_q <= rf_rd;
		end
		if (state_q == ST_DECODE) begin
			insn_q <= buf_q[63:32];
		end
		if (state_q == ST_REGRD) begin
			unique case (cnt_q)
				4'd1: opa_q <= rf_rd;
				4'd2: opb_q <= rf_rd;
				4'd3: opc_q <= rf_rd;
				default: opa_q <= opa_q;
			endcase
		end
		if (state_q == ST_MUL) begin
			if (cnt_q == 4'd0) begin
				prod_q <= mul_p;
			end else begin
				prod_q <= prod_q + {mul_p[31:0], 32'd0};
			end
		end
		if (state_q == ST_EXEC) begin
			ea_q <= xr.mem_ea[AW-1:0];
			len8_q <= xr.mem_8;
			tix_q <= xr.t_idx;
			stv_q <= xr.st_val;
		end
		if (out_load) begin
			m_axis_tdata <= {2'b00, fault_q, halted_q, fl_q, pc_q, buf_q[63:32], regv_q};
		end
	end

	a_rf_no_zero_reg: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != ZERO_REG)
		else $error("write to the zero register");

	a_halt_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> func_q == FUNC_EXEC)
		else $error("halt set outside an execute transfer");

	a_fault_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |-> func_q == FUNC_EXEC)
		else $error("fault outside an execute transfer");

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STWR) |-> (cnt_q < (len8_q ? 4'd8 : 4'd4)) && !fault_q)
		else $error("store beyond its size or after a fault");

endmodule

// ===== tb/a64_subset_instruction_executor_test.sv =====
module a64_subset_instruction_executor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import a64_pkg::*;

	localparam int MEM_SIZE = 65536;
	localparam logic [1:0] FUNC_READ_ALT = 2'd3;
	localparam logic [14:0] PW_MAX = 15'd16384;
	localparam int FIRST_EXEC_ROW = 5;

	typedef struct packed {
		logic [63:0] reg_value;
		logic [31:0] word;
		logic [63:0] pc;
		logic [3:0]  nzcv;
		logic        halted;
		logic        fault;
	} result_t;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] addr;
		logic [31:0] data;
		logic [4:0]  ri;
		bit          typed;
		result_t     want;
	} stim_row_t;

	localparam result_t RESET_VIEW = '{64'd0, 32'd0, 64'd0, FLAGS_RESET, 1'b0, 1'b0};
	localparam result_t WRAP_VIEW = '{64'd0, 32'hA5C3F00F, 64'd0, FLAGS_RESET, 1'b0, 1'b0};
	localparam result_t LOW_VIEW = '{64'd0, 32'h0000A5C3, 64'd0, FLAGS_RESET, 1'b0, 1'b0};

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata;  // mem_address, mem_data, reg_index
	logic [1:0] s_axis_tuser;   // func
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [167:0] m_axis_tdata; // reg_value, mem_word, pc_value, nzcv, halted, fault
	logic cfg_valid;
	logic cfg_ready;
	logic [14:0] cfg_data;

	a64_subset_instruction_executor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// architectural state of the executor
	logic [63:0] arch_x [31];
	logic [63:0] arch_pc;
	logic [3:0] arch_flags;
	logic [7:0] arch_mem [MEM_SIZE];
	bit arch_halt;
	logic [14:0] arch_pw;

	result_t pending_results[$];
	int errors;
	int hold_cycles;
	int rx_stall;
	int rx_calm;
	int tx_calm;
	bit squeeze;

	stim_row_t dir_rows [] = '{
		'{FUNC_READ, 16'h0000, 32'h0, 5'd0, 1'b1, RESET_VIEW},
		'{FUNC_READ, 16'hFFFF, 32'h0, ZERO_REG, 1'b1, RESET_VIEW},
		'{FUNC_READ_ALT, 16'h1234, 32'h0, 5'd30, 1'b1, RESET_VIEW},
		'{FUNC_WRITE, 16'hFFFE, 32'hA5C3F00F, ZERO_REG, 1'b1, WRAP_VIEW},
		'{FUNC_READ, 16'h0000, 32'h0, 5'd0, 1'b1, LOW_VIEW},
		'{FUNC_WRITE, 16'h0000, 32'hD2FFFFE1, 5'd1, 1'b0, '0},
		'{FUNC_EXEC, 16'h0000, 32'h0, 5'd1, 1'b0, '0},
		'{FUNC_WRITE, 16'h0004, 32'h92800002, 5'd2, 1'b0, '0},
		'{FUNC_EXEC, 16'h0004, 32'h0, 5'd2, 1'b0, '0},
		'{FUNC_WRITE, 16'h0008, 32'hB1000443, 5'd3, 1'b0, '0},
		'{FUNC_EXEC, 16'h0008, 32'h0, 5'd3, 1'b0, '0},
		'{FUNC_WRITE, 16'h000C, 32'hEB02003F, ZERO_REG, 1'b0, '0},
		'{FUNC_EXEC, 16'h000C, 32'h0, ZERO_REG, 1'b0, '0},
		'{FUNC_WRITE, 16'h0010, 32'h2B020045, 5'd5, 1'b0, '0},
		'{FUNC_EXEC, 16'h0010, 32'h0, 5'd5, 1'b0, '0},
		'{FUNC_WRITE, 16'h0014, 32'hF2A24682, 5'd2, 1'b0, '0},
		'{FUNC_EXEC, 16'h0014, 32'h0, 5'd2, 1'b0, '0},
		'{FUNC_WRITE, 16'h0018, 32'hEAC21026, 5'd6, 1'b0, '0},
		'{FUNC_EXEC, 16'h0018, 32'h0, 5'd6, 1'b0, '0},
		'{FUNC_WRITE, 16'h001C, 32'hCA61FC47, 5'd7, 1'b0, '0},
		'{FUNC_EXEC, 16'h001C, 32'h0, 5'd7, 1'b0, '0},
		'{FUNC_WRITE, 16'h0020, 32'h9B020C28, 5'd8, 1'b0, '0},
		'{FUNC_EXEC, 16'h0020, 32'h0, 5'd8, 1'b0, '0},
		'{FUNC_WRITE, 16'h0024, 32'hF90403E2, 5'd2, 1'b0, '0},
		'{FUNC_EXEC, 16'h0800, 32'h0, 5'd2, 1'b0, '0},
		'{FUNC_WRITE, 16'h0028, 32'h5800004E, 5'd14, 1'b0, '0},
		'{FUNC_EXEC, 16'h0030, 32'h0, 5'd14, 1'b0, '0},
		'{FUNC_WRITE, 16'h002C, 32'hF861694D, 5'd13, 1'b0, '0},
		'{FUNC_EXEC, 16'h002C, 32'h0, 5'd13, 1'b0, '0},
		'{FUNC_WRITE, 16'h0030, 32'h54000041, 5'd0, 1'b0, '0},
		'{FUNC_EXEC, 16'h0030, 32'h0, 5'd0, 1'b0, '0}
	};

	function automatic logic [63:0] rg(logic [4:0] ix);
		return ix < 5'd31 ? arch_x[ix] : 64'd0;
	endfunction

	function automatic void wr(logic [4:0] ix, logic [63:0] v);
		if (ix < 5'd31) begin
			arch_x[ix] = v;
		end
	endfunction

	function automatic logic [63:0] sext(logic [63:0] v, int n);
		v &= (64'd1 << n) - 64'd1;
		if (v[n-1]) begin
			v |= ~64'd0 << n;
		end
		return v;
	endfunction

	function automatic logic [31:0] rd_word(logic [63:0] a);
		logic [31:0] v;
		logic [15:0] ix;
		v = '0;
		for (int k = 0; k < 4; k++) begin
			ix = a[15:0] + 16'(k);
			v |= 32'(arch_mem[ix]) << (8 * k);
		end
		return v;
	endfunction

	function automatic logic [63:0] shift_operand(logic [63:0] v, logic [1:0] sty,
			int unsigned amt, bit wide);
		logic [63:0] m;
		logic [63:0] r;
		int unsigned w;
		m = wide ? ~64'd0 : 64'hFFFFFFFF;
		w = wide ? 64 : 32;
		v &= m;
		amt = amt % w;
		if (amt == 0) begin
			return v;
		end
		case (sty)
			2'd0: return (v << amt) & m;
			2'd1: return v >> amt;
			2'd2: begin
				r = v >> amt;
				if (v[w-1]) begin
					r |= m & ~(m >> amt);
				end
				return r;
			end
			default: return ((v >> amt) | (v << (w - amt))) & m;
		endcase
	endfunction

	function automatic void set_nz(logic [63:0] v, bit wide, logic [3:0] cv);
		logic [3:0] f;
		f = cv;
		f[3] = wide ? v[63] : v[31];
		f[2] = (v == 64'd0);
		arch_flags = f;
	endfunction

	function automatic logic [63:0] add_sub(logic [63:0] a, logic [63:0] b, bit minus,
			bit setf, bit wide);
		logic [63:0] m;
		logic [63:0] b2;
		logic [63:0] val;
		logic [64:0] full;
		logic [3:0] cv;
		bit carry;
		m = wide ? ~64'd0 : 64'hFFFFFFFF;
		a &= m;
		b2 = (minus ? ~b : b) & m;
		full = {1'b0, a} + {1'b0, b2} + 65'(minus);
		val = full[63:0] & m;
		carry = wide ? full[64] : full[32];
		if (setf) begin
			cv = '0;
			cv[1] = carry;
			cv[0] = wide ? ((a[63] ^ val[63]) & (b2[63] ^ val[63]))
				: ((a[31] ^ val[31]) & (b2[31] ^ val[31]));
			set_nz(val, wide, cv);
		end
		return val;
	endfunction

	function automatic bit cond_holds(logic [3:0] cc);
		bit n;
		bit z;
		bit c;
		bit v;
		bit r;
		{n, z, c, v} = arch_flags;
		case (cc[3:1])
			3'd0: r = z;
			3'd1: r = c;
			3'd2: r = n;
			3'd3: r = v;
			3'd4: r = c && !z;
			3'd5: r = (n == v);
			3'd6: r = (n == v) && !z;
			default: r = 1'b1;
		endcase
		if (cc[0] && cc != 4'd15) begin
			r = !r;
		end
		return r;
	endfunction

	function automatic bit arch_transfer(logic [31:0] insn);
		logic [63:0] sz;
		logic [63:0] ea;
		logic [63:0] off9;
		logic [63:0] val;
		logic [15:0] ix;
		bit ld;
		sz = insn[30] ? 64'd8 : 64'd4;
		if (insn[31]) begin
			ld = insn[22];
			if (insn[24]) begin
				ea = rg(insn[9:5]) + 64'(insn[21:10]) * sz;
			end else if (insn[21]) begin
				ea = rg(insn[9:5]) + rg(insn[20:16]);
			end else begin
				off9 = sext(64'(insn[20:12]), 9);
				if (insn[11]) begin
					ea = rg(insn[9:5]) + off9;
					wr(insn[9:5], ea);
				end else begin
					ea = rg(insn[9:5]);
					wr(insn[9:5], ea + off9);
				end
			end
		end else begin
			ld = 1'b1;
			ea = arch_pc + (sext(64'(insn[23:5]), 19) << 2);
		end
		if (ea > 64'(MEM_SIZE) - sz) begin
			return 1'b1;
		end
		if (ld) begin
			val = '0;
			for (int k = 0; k < int'(sz); k++) begin
				ix = ea[15:0] + 16'(k);
				val |= 64'(arch_mem[ix]) << (8 * k);
			end
			wr(insn[4:0], val);
		end else begin
			val = rg(insn[4:0]);
			for (int k = 0; k < int'(sz); k++) begin
				ix = ea[15:0] + 16'(k);
				arch_mem[ix] = val[8*k +: 8];
			end
		end
		return 1'b0;
	endfunction

	function automatic bit arch_exec();
		logic [31:0] insn;
		logic [63:0] m;
		logic [63:0] nextpc;
		logic [63:0] imm;
		logic [63:0] hole;
		logic [63:0] op2;
		logic [63:0] a;
		logic [63:0] val;
		logic [63:0] prod;
		logic [63:0] acc;
		logic [4:0] d;
		logic [4:0] n;
		logic [4:0] mi;
		logic [1:0] opf;
		bit wide;
		bit fault;
		fault = 1'b0;
		if (arch_halt) begin
			return 1'b0;
		end
		if (arch_pc / 4 >= 64'(arch_pw)) begin
			arch_halt = 1'b1;
			return 1'b0;
		end
		insn = rd_word(arch_pc);
		if (insn == HALT_INSN) begin
			arch_halt = 1'b1;
			return 1'b0;
		end
		nextpc = arch_pc + 64'd4;
		wide = insn[31];
		m = wide ? ~64'd0 : 64'hFFFFFFFF;
		d = insn[4:0];
		n = insn[9:5];
		mi = insn[20:16];
		opf = insn[30:29];
		if (insn[28:26] == 3'b100) begin
			if (insn[25:23] == 3'b010) begin
				imm = 64'(insn[21:10]);
				if (insn[22]) begin
					imm = imm << 12;
				end
				wr(d, add_sub(rg(n), imm, opf[1], opf[0], wide));
			end else if (insn[25:23] == 3'b101) begin
				imm = 64'(insn[20:5]) << (16 * insn[22:21]);
				hole = 64'hFFFF << (16 * insn[22:21]);
				if (opf == 2'd0) begin
					wr(d, ~imm & m);
				end else if (opf == 2'd2) begin
					wr(d, imm & m);
				end else if (opf == 2'd3) begin
					wr(d, ((rg(d) & ~hole) | imm) & m);
				end
			end
		end else if (insn[27:25] == 3'b101) begin
			if (!insn[28] && insn[24]) begin
				op2 = shift_operand(rg(mi), insn[23:22] == 2'd3 ? 2'd2 : insn[23:22],
					insn[15:10], wide);
				wr(d, add_sub(rg(n), op2, opf[1], opf[0], wide));
			end else if (insn[28]) begin
				prod = rg(n) * rg(mi);
				acc = rg(insn[14:10]);
				wr(d, (insn[15] ? acc - prod : acc + prod) & m);
			end else begin
				op2 = shift_operand(rg(mi), insn[23:22], insn[15:10], wide);
				a = rg(n) & m;
				if (insn[21]) begin
					op2 = ~op2 & m;
				end
				if (opf == 2'd1) begin
					val = a | op2;
				end else if (opf == 2'd2) begin
					val = a ^ op2;
				end else begin
					val = a & op2;
				end
				if (opf == 2'd3) begin
					set_nz(val, wide, 4'd0);
				end
				wr(d, val);
			end
		end else if (insn[27] && !insn[25]) begin
			fault = arch_transfer(insn);
		end else if (insn[28:26] == 3'b101) begin
			if (insn[31:29] == 3'd0) begin
				nextpc = arch_pc + (sext(64'(insn[25:0]), 26) << 2);
			end else if (insn[31:29] == 3'd6) begin
				nextpc = rg(n);
			end else if (insn[31:29] == 3'd2 && cond_holds(insn[3:0])) begin
				nextpc = arch_pc + (sext(64'(insn[23:5]), 19) << 2);
			end
		end
		arch_pc = nextpc;
		return fault;
	endfunction

	function automatic result_t arch_step(logic [1:0] func, logic [15:0] addr,
			logic [31:0] data, logic [4:0] ri);
		result_t r;
		logic [15:0] ix;
		bit fault;
		fault = 1'b0;
		if (func == FUNC_WRITE) begin
			for (int k = 0; k < 4; k++) begin
				ix = addr + 16'(k);
				arch_mem[ix] = data[8*k +: 8];
			end
		end else if (func == FUNC_EXEC) begin
			fault = arch_exec();
		end
		r.reg_value = rg(ri);
		r.word = rd_word(64'(addr));
		r.pc = arch_pc;
		r.nzcv = arch_flags;
		r.halted = arch_halt;
		r.fault = fault;
		return r;
	endfunction

	function automatic logic [4:0] pick_small_reg(logic [63:0] lim);
		logic [4:0] r;
		for (int t = 0; t < 6; t++) begin
			r = 5'($urandom_range(0, 30));
			if (arch_x[r] < lim) begin
				return r;
			end
		end
		return ZERO_REG;
	endfunction

	// next instruction for the current pc, kept inside the program window
	function automatic logic [31:0] gen_instruction();
		logic [31:0] w;
		logic [4:0] rn;
		logic [4:0] rm;
		logic [11:0] off12;
		int cap;
		int lo;
		int hi;
		int k;
		cap = int'(arch_pw) * 4;
		lo = -int'(arch_pc / 4);
		hi = (cap - 4 - int'(arch_pc)) / 4;
		k = lo + int'($urandom_range(0, hi - lo));
		if (arch_pc + 64'd8 > 64'(cap)) begin
			return {6'b000101, 26'(k)};
		end
		w = $urandom;
		rn = ($urandom % 8 == 0) ? 5'($urandom) : pick_small_reg(64'hF000);
		case ($urandom_range(0, 12))
			0: w[28:23] = 6'b100010;
			1: w[28:23] = 6'b100101;
			2: begin
				w[28:24] = 5'b01011;
				w[21] = 1'b0;
			end
			3: w[28:24] = 5'b01010;
			4: w[28:24] = 5'b11011;
			5: begin
				off12 = ($urandom % 8 == 0) ? 12'hFFF : 12'($urandom_range(0, 255));
				w = {1'b1, w[30], 6'b111001, 1'b0, w[22], off12, rn, w[4:0]};
			end
			6: begin
				rm = pick_small_reg(64'h1000);
				w = {1'b1, w[30], 6'b111000, 1'b0, w[22], 1'b1, rm, w[15:10], rn, w[4:0]};
			end
			7: w = {1'b1, w[30], 6'b111000, 1'b0, w[22], 1'b0, w[20:12], w[11], 1'b1,
				rn, w[4:0]};
			8: begin
				lo = -int'(arch_pc / 4);
				hi = (65528 - int'(arch_pc)) / 4;
				k = lo + int'($urandom_range(0, hi - lo));
				if ($urandom % 6 != 0) begin
					w[23:5] = 19'(k);
				end
				w[31:24] = {1'b0, w[30], 6'b011000};
			end
			9: w = {6'b000101, 26'(k)};
			10: w = {8'b01010100, 19'(k), 1'b0, w[3:0]};
			11: w = 32'hD61F0000 | (32'(pick_small_reg(64'(cap))) << 5);
			default: begin
				if (w[28:26] == 3'b101) begin
					w[28] = 1'b0;
				end
			end
		endcase
		if (w == HALT_INSN) begin
			w[0] = 1'b1;
		end
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		r = $urandom % 100;
		if (r == 0) begin
			tx_calm = $urandom_range(20, 60);
		end
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 50) begin
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		end
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got.reg_value = m_axis_tdata[63:0];
		got.word = m_axis_tdata[95:64];
		got.pc = m_axis_tdata[159:96];
		got.nzcv = m_axis_tdata[163:160];
		got.halted = m_axis_tdata[164];
		got.fault = m_axis_tdata[165];
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result transfer", 64'(got.pc), 64'd0);
		end else begin
			want = pending_results.pop_front();
			if (got.reg_value !== want.reg_value) begin
				report_mismatch("reg_value", got.reg_value, want.reg_value);
			end
			if (got.word !== want.word) begin
				report_mismatch("mem_word", 64'(got.word), 64'(want.word));
			end
			if (got.pc !== want.pc) begin
				report_mismatch("pc_value", got.pc, want.pc);
			end
			if (got.nzcv !== want.nzcv) begin
				report_mismatch("nzcv", 64'(got.nzcv), 64'(want.nzcv));
			end
			if (got.halted !== want.halted) begin
				report_mismatch("halted", 64'(got.halted), 64'(want.halted));
			end
			if (got.fault !== want.fault) begin
				report_mismatch("fault", 64'(got.fault), 64'(want.fault));
			end
		end
	endtask

	task automatic send_item(logic [1:0] func, logic [15:0] addr, logic [31:0] data,
			logic [4:0] ri, bit typed, result_t want);
		int gap;
		result_t p;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {3'b000, ri, data, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		p = arch_step(func, addr, data, ri);
		pending_results.push_back(typed ? want : p);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_program_words(logic [14:0] v);
		drain();
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		arch_pw = v;
	endtask

	task automatic run_random(int count);
		logic [31:0] insn;
		for (int i = 0; i < count; i++) begin
			if ($urandom % 5 == 0) begin
				send_item(2'($urandom), 16'($urandom), $urandom, 5'($urandom), 1'b0, '0);
			end else begin
				insn = gen_instruction();
				send_item(FUNC_WRITE, arch_pc[15:0], insn, 5'($urandom), 1'b0, '0);
				send_item(FUNC_EXEC, 16'($urandom), $urandom, 5'($urandom), 1'b0, '0);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: check transfers and throttle ready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_result();
		end
		if (squeeze) begin
			hold_cycles = 300;
			squeeze = 1'b0;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else if (rx_calm > 0) begin
			rx_calm--;
			m_axis_tready <= 1'b1;
		end else begin
			case ($urandom % 100)
				0: begin
					rx_calm = $urandom_range(30, 80);
					m_axis_tready <= 1'b1;
				end
				1, 2: begin
					rx_stall = $urandom_range(10, 30);
					m_axis_tready <= 1'b0;
				end
				3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
					rx_stall = $urandom_range(0, 2);
					m_axis_tready <= 1'b0;
				end
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	initial begin
		int lo;
		errors = 0;
		hold_cycles = 0;
		rx_stall = 0;
		rx_calm = 0;
		tx_calm = 0;
		squeeze = 1'b0;
		for (int i = 0; i < 31; i++) begin
			arch_x[i] = '0;
		end
		for (int i = 0; i < MEM_SIZE; i++) begin
			arch_mem[i] = '0;
		end
		arch_pc = '0;
		arch_flags = FLAGS_RESET;
		arch_halt = 1'b0;
		arch_pw = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_rows.size(); i++) begin
			if (i == FIRST_EXEC_ROW) begin
				set_program_words(PW_MAX);
			end
			send_item(dir_rows[i].func, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].ri,
				dir_rows[i].typed, dir_rows[i].want);
		end

		run_random(140);

		// narrower program window, then a long result-side hold-off
		lo = int'(arch_pc / 4) + 8;
		set_program_words(lo > 16383 ? PW_MAX : 15'($urandom_range(lo, 16383)));
		squeeze = 1'b1;
		run_random(140);

		if ($urandom % 2 == 0) begin
			send_item(FUNC_WRITE, arch_pc[15:0], HALT_INSN, 5'($urandom), 1'b0, '0);
			send_item(FUNC_EXEC, 16'($urandom), $urandom, 5'($urandom), 1'b0, '0);
			set_program_words(15'd0);
		end else begin
			set_program_words(15'd0);
		end
		for (int i = 0; i < 6; i++) begin
			send_item(FUNC_EXEC, 16'($urandom), $urandom, 5'($urandom), 1'b0, '0);
			send_item(FUNC_READ, 16'($urandom), $urandom, 5'($urandom), 1'b0, '0);
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/a64_pkg.sv
design/a64_ram.sv
design/a64_exec.sv
design/a64_subset_instruction_executor.sv
tb/a64_subset_instruction_executor_test.sv
